/* hw/rtl/ctl_pkg.sv */
// ---------------------------------------------------------------------------
// ctl_pkg
// Shared types and constants for the token lexer: token kinds, error causes,
// scan modes and the payload structs of both channels.
// ---------------------------------------------------------------------------
package ctl_pkg;

    localparam int KW_COUNT = 9;

    // Token kinds.
    localparam logic [5:0] TK_EOF       = 6'd0;
    localparam logic [5:0] TK_IDENT     = 6'd1;
    localparam logic [5:0] TK_NUMBER    = 6'd2;
    localparam logic [5:0] TK_CHAR      = 6'd3;
    localparam logic [5:0] TK_STRING    = 6'd4;
    localparam logic [5:0] TK_BOOL_LIT  = 6'd5;
    localparam logic [5:0] TK_KW_INT    = 6'd6;
    localparam logic [5:0] TK_KW_FLOAT  = 6'd7;
    localparam logic [5:0] TK_KW_BOOL   = 6'd8;
    localparam logic [5:0] TK_KW_CHAR   = 6'd9;
    localparam logic [5:0] TK_KW_STRING = 6'd10;
    localparam logic [5:0] TK_KW_IF     = 6'd11;
    localparam logic [5:0] TK_KW_ELSE   = 6'd12;
    localparam logic [5:0] TK_ASSIGN    = 6'd13;
    localparam logic [5:0] TK_EQ        = 6'd14;
    localparam logic [5:0] TK_NOT       = 6'd15;
    localparam logic [5:0] TK_NE        = 6'd16;
    localparam logic [5:0] TK_LT        = 6'd17;
    localparam logic [5:0] TK_LE        = 6'd18;
    localparam logic [5:0] TK_GT        = 6'd19;
    localparam logic [5:0] TK_GE        = 6'd20;
    localparam logic [5:0] TK_PLUS      = 6'd21;
    localparam logic [5:0] TK_MINUS     = 6'd22;
    localparam logic [5:0] TK_STAR      = 6'd23;
    localparam logic [5:0] TK_SLASH     = 6'd24;
    localparam logic [5:0] TK_SEMI      = 6'd25;
    localparam logic [5:0] TK_LPAREN    = 6'd26;
    localparam logic [5:0] TK_RPAREN    = 6'd27;
    localparam logic [5:0] TK_LBRACE    = 6'd28;
    localparam logic [5:0] TK_RBRACE    = 6'd29;
    localparam logic [5:0] TK_AND       = 6'd30;
    localparam logic [5:0] TK_OR        = 6'd31;
    localparam logic [5:0] TK_CARET     = 6'd32;
    localparam logic [5:0] TK_ERROR     = 6'd33;

    // Error causes.
    localparam logic [1:0] ERR_NONE        = 2'd0;
    localparam logic [1:0] ERR_UNTERM_CHAR = 2'd1;
    localparam logic [1:0] ERR_UNTERM_STR  = 2'd2;
    localparam logic [1:0] ERR_UNEXPECTED  = 2'd3;

    // Scanner modes.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_IDENT,
        MODE_NUMBER,
        MODE_CHAR1,
        MODE_CHAR2,
        MODE_STRING,
        MODE_OP
    } scan_mode_t;

    typedef struct packed {
        logic [7:0] source_byte;
        logic       end_of_input;
    } lex_in_t;

    typedef struct packed {
        logic [5:0]  token_kind;
        logic [1:0]  error_cause;
        logic [23:0] start_line;
        logic [31:0] start_offset;
        logic [7:0]  token_length;
        logic        too_long;
        logic [7:0]  char_value;
        logic        last_of_run;
    } lex_out_t;

    // Up to two tokens per byte, as produced by the front scanner.
    typedef struct packed {
        logic     first_valid;
        lex_out_t first;
        logic     second_valid;
        lex_out_t second;
    } tok_pair_t;

    // Keyword letter at a given position, zero past the keyword end.
    function automatic logic [7:0] kw_char(input int unsigned k, input logic [2:0] pos);
        logic [47:0] txt;
        begin
            unique case (k)
                0:       txt = {"int", 24'd0};
                1:       txt = {"float", 8'd0};
                2:       txt = {"bool", 16'd0};
                3:       txt = {"char", 16'd0};
                4:       txt = "string";
                5:       txt = {"if", 32'd0};
                6:       txt = {"else", 16'd0};
                7:       txt = {"true", 16'd0};
                default: txt = {"false", 8'd0};
            endcase
            kw_char = (pos > 3'd5) ? 8'd0 : txt[8'(47 - 8 * int'(pos)) -: 8];
        end
    endfunction

    function automatic logic [2:0] kw_len(input int unsigned k);
        begin
            unique case (k)
                0:       kw_len = 3'd3;
                1:       kw_len = 3'd5;
                2:       kw_len = 3'd4;
                3:       kw_len = 3'd4;
                4:       kw_len = 3'd6;
                5:       kw_len = 3'd2;
                6:       kw_len = 3'd4;
                7:       kw_len = 3'd4;
                default: kw_len = 3'd5;
            endcase
        end
    endfunction

    function automatic logic [5:0] kw_kind(input int unsigned k);
        begin
            unique case (k)
                0:       kw_kind = TK_KW_INT;
                1:       kw_kind = TK_KW_FLOAT;
                2:       kw_kind = TK_KW_BOOL;
                3:       kw_kind = TK_KW_CHAR;
                4:       kw_kind = TK_KW_STRING;
                5:       kw_kind = TK_KW_IF;
                6:       kw_kind = TK_KW_ELSE;
                default: kw_kind = TK_BOOL_LIT;
            endcase
        end
    endfunction

    // Single-character operators; TK_EOF means none.
    function automatic logic [5:0] single_op(input logic [7:0] c);
        begin
            unique case (c)
                "+":     single_op = TK_PLUS;
                "-":     single_op = TK_MINUS;
                "*":     single_op = TK_STAR;
                "/":     single_op = TK_SLASH;
                ";":     single_op = TK_SEMI;
                "(":     single_op = TK_LPAREN;
                ")":     single_op = TK_RPAREN;
                "{":     single_op = TK_LBRACE;
                "}":     single_op = TK_RBRACE;
                "^":     single_op = TK_CARET;
                default: single_op = TK_EOF;
            endcase
        end
    endfunction

endpackage

/* hw/rtl/ctl_scanner.sv */
// ---------------------------------------------------------------------------
// ctl_scanner
// Front part: takes one byte per beat, advances the scan state and produces
// zero, one or two finished tokens for that byte.
// ---------------------------------------------------------------------------
module ctl_scanner
    import ctl_pkg::*;
#(
    parameter int WORD_LIMIT = 63,
    parameter int TEXT_LIMIT = 255,
    parameter int LINE_BITS  = 24
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      step,
    input  lex_in_t   in_data,
    output tok_pair_t pair
);

    localparam logic [LINE_BITS-1:0] LINE_MAX = {LINE_BITS{1'b1}};

    scan_mode_t            mode_reg, mode_next;
    logic [KW_COUNT-1:0]   cand_reg, cand_next;
    logic [7:0]            bytes_reg, bytes_next;
    logic                  ovf_reg, ovf_next;
    logic [LINE_BITS-1:0]  line_reg, line_next;
    logic [31:0]           pos_reg, pos_next;
    logic [LINE_BITS-1:0]  tline_reg, tline_next;
    logic [31:0]           tpos_reg, tpos_next;
    logic [7:0]            held_reg, held_next;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            cand_reg  <= '0;
            bytes_reg <= '0;
            ovf_reg   <= 1'b0;
            line_reg  <= LINE_BITS'(1);
            pos_reg   <= '0;
            tline_reg <= LINE_BITS'(1);
            tpos_reg  <= '0;
            held_reg  <= '0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            cand_reg  <= cand_next;
            bytes_reg <= bytes_next;
            ovf_reg   <= ovf_next;
            line_reg  <= line_next;
            pos_reg   <= pos_next;
            tline_reg <= tline_next;
            tpos_reg  <= tpos_next;
            held_reg  <= held_next;
        end
    end

    logic [7:0] c;
    logic       eoi;
    logic       c_alpha, c_digit, c_word, c_blank;
    logic [LINE_BITS-1:0] line_inc;
    logic [23:0] line_out, tline_out;
    logic [KW_COUNT-1:0] cand_match;
    logic [5:0] word_kind, lone_kind;
    logic [1:0] lone_cause;

    assign c       = in_data.source_byte;
    assign eoi     = in_data.end_of_input;
    assign c_alpha = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
    assign c_digit = (c >= "0" && c <= "9");
    assign c_word  = c_alpha || c_digit || (c == "_");
    assign c_blank = (c == " ") || (c == 8'h09) || (c == 8'h0D);
    assign line_inc = (line_reg == LINE_MAX) ? line_reg : line_reg + 1'b1;
    assign line_out  = 24'(line_reg);
    assign tline_out = 24'(tline_reg);

    // Keyword mask update for the byte at the current length.
    always_comb
    begin
        for (int k = 0; k < KW_COUNT; k++)
        begin
            cand_match[k] = cand_reg[k] && (bytes_reg < 8'(kw_len(k)))
                            && (kw_char(k, bytes_reg[2:0]) == c);
        end
    end

    // Keyword lookup at flush time, lowest index first.
    always_comb
    begin
        word_kind = TK_IDENT;
        for (int k = KW_COUNT - 1; k >= 0; k--)
        begin
            if (cand_reg[k] && (8'(kw_len(k)) == bytes_reg))
                word_kind = kw_kind(k);
        end
    end

    // Kind of a pending one-character operator.
    always_comb
    begin
        lone_cause = ERR_NONE;
        unique case (held_reg)
            "=":     lone_kind = TK_ASSIGN;
            "!":     lone_kind = TK_NOT;
            "<":     lone_kind = TK_LT;
            ">":     lone_kind = TK_GT;
            default:
            begin
                lone_kind  = TK_ERROR;
                lone_cause = ERR_UNEXPECTED;
            end
        endcase
    end

    function automatic lex_out_t mk(input logic [5:0] kind, input logic [1:0] cause,
                                    input logic [23:0] ln, input logic [31:0] ps,
                                    input logic [7:0] len, input logic tl,
                                    input logic [7:0] cv);
        lex_out_t t;
        begin
            t.token_kind   = kind;
            t.error_cause  = cause;
            t.start_line   = ln;
            t.start_offset = ps;
            t.token_length = len;
            t.too_long     = tl;
            t.char_value   = cv;
            t.last_of_run  = 1'b0;
            mk = t;
        end
    endfunction

    // Next state and emitted tokens.
    always_comb
    begin
        logic       restart;
        logic       e0_v, e1_v;
        lex_out_t   e0, e1;
        logic [5:0] k2;
        logic [5:0] so;

        mode_next  = mode_reg;
        cand_next  = cand_reg;
        bytes_next = bytes_reg;
        ovf_next   = ovf_reg;
        line_next  = line_reg;
        pos_next   = pos_reg + 32'd1;
        tline_next = tline_reg;
        tpos_next  = tpos_reg;
        held_next  = held_reg;
        restart    = 1'b0;
        e0_v       = 1'b0;
        e1_v       = 1'b0;
        e0         = '0;
        e1         = '0;
        k2         = TK_EOF;
        so         = single_op(c);

        if (eoi)
        begin
            pos_next  = pos_reg;
            mode_next = MODE_IDLE;
            unique case (mode_reg)
                MODE_IDENT, MODE_NUMBER:
                begin
                    e0_v = 1'b1;
                    e0 = mk((mode_reg == MODE_IDENT) ? word_kind : TK_NUMBER, ERR_NONE,
                            tline_out, tpos_reg, bytes_reg, ovf_reg, held_reg);
                end
                MODE_CHAR1, MODE_CHAR2:
                begin
                    e0_v = 1'b1;
                    e0 = mk(TK_ERROR, ERR_UNTERM_CHAR, tline_out, tpos_reg, bytes_reg,
                            1'b0, held_reg);
                end
                MODE_STRING:
                begin
                    e0_v = 1'b1;
                    e0 = mk(TK_ERROR, ERR_UNTERM_STR, tline_out, tpos_reg, bytes_reg,
                            ovf_reg, held_reg);
                end
                MODE_OP:
                begin
                    e0_v = 1'b1;
                    e0 = mk(lone_kind, lone_cause, tline_out, tpos_reg, 8'd1, 1'b0, held_reg);
                end
                default: ;
            endcase
            e1_v = 1'b1;
            e1 = mk(TK_EOF, ERR_NONE, line_out, pos_reg, 8'd0, 1'b0, 8'd0);
        end
        else
        begin
            unique case (mode_reg)
                MODE_IDENT, MODE_NUMBER:
                begin
                    if ((mode_reg == MODE_IDENT) ? c_word : (c_digit || c == "."))
                    begin
                        if (bytes_reg >= 8'(WORD_LIMIT))
                            ovf_next = 1'b1;
                        if (mode_reg == MODE_IDENT)
                            cand_next = cand_match;
                        if (bytes_reg != 8'd255)
                            bytes_next = bytes_reg + 8'd1;
                    end
                    else
                    begin
                        e0_v = 1'b1;
                        e0 = mk((mode_reg == MODE_IDENT) ? word_kind : TK_NUMBER, ERR_NONE,
                                tline_out, tpos_reg, bytes_reg, ovf_reg, held_reg);
                        restart = 1'b1;
                    end
                end
                MODE_CHAR1:
                begin
                    held_next  = c;
                    bytes_next = 8'd1;
                    if (c == 8'h0A)
                        line_next = line_inc;
                    mode_next = MODE_CHAR2;
                end
                MODE_CHAR2:
                begin
                    e0_v = 1'b1;
                    if (c == "'")
                        e0 = mk(TK_CHAR, ERR_NONE, tline_out, tpos_reg, 8'd1, 1'b0, held_reg);
                    else
                    begin
                        if (c == 8'h0A)
                            line_next = line_inc;
                        e0 = mk(TK_ERROR, ERR_UNTERM_CHAR, tline_out, tpos_reg, 8'd2,
                                1'b0, held_reg);
                    end
                    mode_next = MODE_IDLE;
                end
                MODE_STRING:
                begin
                    if (c == "\"")
                    begin
                        e0_v = 1'b1;
                        e0 = mk(TK_STRING, ERR_NONE, tline_out, tpos_reg, bytes_reg,
                                ovf_reg, held_reg);
                        mode_next = MODE_IDLE;
                    end
                    else if (c == 8'h0A)
                    begin
                        line_next = line_inc;
                        e0_v = 1'b1;
                        e0 = mk(TK_ERROR, ERR_UNTERM_STR, tline_out, tpos_reg, bytes_reg,
                                ovf_reg, held_reg);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        if (bytes_reg == 8'd0)
                            held_next = c;
                        if (bytes_reg >= 8'(TEXT_LIMIT))
                            ovf_next = 1'b1;
                        if (bytes_reg != 8'd255)
                            bytes_next = bytes_reg + 8'd1;
                    end
                end
                MODE_OP:
                begin
                    if (c == "=")
                    begin
                        priority case (held_reg)
                            "=":     k2 = TK_EQ;
                            "!":     k2 = TK_NE;
                            "<":     k2 = TK_LE;
                            ">":     k2 = TK_GE;
                            default: k2 = TK_EOF;
                        endcase
                    end
                    else if (c == "&" && held_reg == "&")
                        k2 = TK_AND;
                    else if (c == "|" && held_reg == "|")
                        k2 = TK_OR;
                    e0_v = 1'b1;
                    if (k2 != TK_EOF)
                    begin
                        e0 = mk(k2, ERR_NONE, tline_out, tpos_reg, 8'd2, 1'b0, held_reg);
                        mode_next = MODE_IDLE;
                    end
                    else
                    begin
                        e0 = mk(lone_kind, lone_cause, tline_out, tpos_reg, 8'd1, 1'b0,
                                held_reg);
                        restart = 1'b1;
                    end
                end
                default: restart = 1'b1;
            endcase

            // Lex the byte afresh from between tokens.
            if (restart)
            begin
                mode_next = MODE_IDLE;
                if (c_blank)
                begin
                end
                else if (c == 8'h0A)
                    line_next = line_inc;
                else if (c_word)
                begin
                    tline_next = line_reg;
                    tpos_next  = pos_reg;
                    bytes_next = 8'd1;
                    ovf_next   = (WORD_LIMIT == 0);
                    held_next  = c;
                    mode_next  = c_digit ? MODE_NUMBER : MODE_IDENT;
                    for (int k = 0; k < KW_COUNT; k++)
                        cand_next[k] = c_digit || (kw_char(k, 3'd0) == c);
                end
                else if (c == "'" || c == "\"")
                begin
                    tline_next = line_reg;
                    tpos_next  = pos_reg;
                    bytes_next = 8'd0;
                    ovf_next   = 1'b0;
                    held_next  = 8'd0;
                    mode_next  = (c == "\"") ? MODE_STRING : MODE_CHAR1;
                end
                else if (c == "=" || c == "!" || c == "<" || c == ">" || c == "&" || c == "|")
                begin
                    tline_next = line_reg;
                    tpos_next  = pos_reg;
                    bytes_next = 8'd0;
                    ovf_next   = 1'b0;
                    held_next  = c;
                    mode_next  = MODE_OP;
                end
                else
                begin
                    e1_v = 1'b1;
                    if (so != TK_EOF)
                        e1 = mk(so, ERR_NONE, line_out, pos_reg, 8'd1, 1'b0, c);
                    else
                        e1 = mk(TK_ERROR, ERR_UNEXPECTED, line_out, pos_reg, 8'd1, 1'b0, c);
                end
            end
        end

        // Pack the pair with the earlier token first and mark the last one.
        if (e0_v && e1_v)
        begin
            e1.last_of_run = 1'b1;
            pair.first_valid  = 1'b1;
            pair.first        = e0;
            pair.second_valid = 1'b1;
            pair.second       = e1;
        end
        else if (e0_v)
        begin
            e0.last_of_run = 1'b1;
            pair.first_valid  = 1'b1;
            pair.first        = e0;
            pair.second_valid = 1'b0;
            pair.second       = e1;
        end
        else
        begin
            e1.last_of_run = 1'b1;
            pair.first_valid  = e1_v;
            pair.first        = e1;
            pair.second_valid = 1'b0;
            pair.second       = e0;
        end
    end

endmodule

/* hw/rtl/ctl_token_queue.sv */
// ---------------------------------------------------------------------------
// ctl_token_queue
// Back part: a small token queue that takes up to two tokens per beat from
// the scanner and drives one token per beat to the output channel.
// ---------------------------------------------------------------------------
module ctl_token_queue
    import ctl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  tok_pair_t pair,
    output logic      has_room,
    output logic      out_valid,
    input  logic      out_ready,
    output lex_out_t  out_data
);

    localparam int DEPTH = 4;

    lex_out_t   slot_reg [DEPTH];
    logic [1:0] rd_reg, rd_next;
    logic [1:0] wr_reg, wr_next;
    logic [2:0] cnt_reg, cnt_next;
    logic       pop;
    logic [1:0] n_push;

    assign out_valid = (cnt_reg != 3'd0);
    assign out_data  = slot_reg[rd_reg];
    assign pop       = out_valid && out_ready;
    // Room for a full pair even with nothing leaving.
    assign has_room  = (cnt_reg <= 3'(DEPTH - 2));
    assign n_push    = push ? (2'(pair.first_valid) + 2'(pair.second_valid)) : 2'd0;

    always_comb
    begin
        rd_next  = rd_reg + 2'(pop);
        wr_next  = wr_reg + n_push;
        cnt_next = cnt_reg + 3'(n_push) - 3'(pop);
    end

    // Pointer and count registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= '0;
            wr_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            rd_reg  <= rd_next;
            wr_reg  <= wr_next;
            cnt_reg <= cnt_next;
        end
    end

    // Token storage.
    always_ff @(posedge clk)
    begin
        if (push && pair.first_valid)
            slot_reg[wr_reg] <= pair.first;
        if (push && pair.second_valid)
            slot_reg[wr_reg + 2'd1] <= pair.second;
    end

endmodule

/* hw/rtl/c_like_token_lexer_unit.sv */
// ---------------------------------------------------------------------------
// c_like_token_lexer_unit
// Streaming lexer for a small C-like language, one source byte per beat.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready/in_data) carries a source byte or an
//   end-of-input mark. Output channel (out_valid/out_ready/out_data) carries
//   tokens; the last token caused by one input beat has last_of_run set.
//   A byte completes in the scanner in the cycle it is accepted; its tokens
//   are registered in the token queue and leave it one token per cycle
//   while the receiver is ready. Throughput is one input beat per cycle
//   while the token queue (four entries) has room for two tokens; a beat
//   that yields two tokens takes two output transfers, so a long run of
//   such beats is bounded by the single output port.
//   Reset clears the scan state, sets the line counter to one and the byte
//   offset to zero, and empties the queue.
//   When the receiver stalls, tokens wait in the queue; input is refused
//   once fewer than two free entries remain, and nothing is lost.
// ---------------------------------------------------------------------------
module c_like_token_lexer_unit
    import ctl_pkg::*;
#(
    parameter int WORD_LIMIT = 63,
    parameter int TEXT_LIMIT = 255,
    parameter int LINE_BITS  = 24
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  lex_in_t  in_data,
    output logic     out_valid,
    input  logic     out_ready,
    output lex_out_t out_data
);

    tok_pair_t pair;
    logic      step;

    assign step = in_valid && in_ready;

    ctl_scanner #(
        .WORD_LIMIT (WORD_LIMIT),
        .TEXT_LIMIT (TEXT_LIMIT),
        .LINE_BITS  (LINE_BITS)
    ) u_scanner (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_data (in_data),
        .pair    (pair)
    );

    ctl_token_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (step),
        .pair      (pair),
        .has_room  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule
